@@ src/hue_kmeans_iteration_defines.svh @@
// ----------------------------------------------------------------------------
// hue k-means assertion macros
// shared concurrent check forms, clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef HUE_KMEANS_ITERATION_DEFINES_SVH
`define HUE_KMEANS_ITERATION_DEFINES_SVH

// same-cycle implication
`define HKM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hkm same-cycle check failed");

// next-cycle implication
`define HKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hkm next-cycle check failed");

`endif

@@ src/hkm_pkg.sv @@
// ----------------------------------------------------------------------------
// hkm_pkg
// constants, codes and types shared by the hue k-means block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hkm_pkg;

    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int MAX_PIXELS_DEF   = 1048576;

    localparam int HUE_W    = 16;
    localparam int FRAC_W   = 14;
    localparam int SQ_W     = 2 * HUE_W;
    localparam int ADJ_W    = 35;
    localparam int NUMK_W   = 4;
    localparam int LABEL_W  = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 35;

    // 0.25 in Q2.14
    localparam logic [HUE_W-1:0]  QUARTER    = HUE_W'(1) << (FRAC_W - 2);
    // 0.1 in Q7.28
    localparam logic [ADJ_W-1:0]  THR_RESET  = ADJ_W'(26843546);
    localparam logic [NUMK_W-1:0] NUMK_RESET = NUMK_W'(2);
    localparam logic [ADJ_W-1:0]  ADJ_MAX    = {ADJ_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 1'b1;

    localparam logic FUNC_INIT  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ACC,
        S_UPD,
        S_UPD_WAIT,
        S_INIT,
        S_INIT_WAIT,
        S_DONE
    } t_state;

endpackage

@@ src/hkm_div.sv @@
// ----------------------------------------------------------------------------
// hkm_div
// restoring divider, one quotient bit per cycle, shared by init and mean steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hkm_div
    import hkm_pkg::*;
#(
    parameter int NUM_W = 36,
    parameter int DEN_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_step;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             q_bit;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        q_bit  = !diff[DEN_W+1];
        n_rem  = q_bit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - CNT_W'(1);
                end
            end
        end
    end

    // quotient bits shift into the numerator register
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ src/hue_kmeans_iteration.sv @@
// ----------------------------------------------------------------------------
// hue_kmeans_iteration
// one-dimensional k-means over Q2.14 hues with a shared distance unit and
// a shared iterative divider under one sequencer
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s stream  in   i_s_tvalid / o_s_tready   tdata hue, tuser func, tlast last
// m stream  out  o_m_tvalid / i_m_tready   tdata label/adjustment/converged,
//                                          tuser pass_done
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// pixel beat: a search over the active centroids, one centroid compared per
//             cycle in the distance unit, then the accumulate step and the result
// last pixel: plus a sweep over all MAX_CLUSTERS entries, a divider run per
//             non-empty active cluster, the other entries only cleared
// init beat and reset: a sweep over all MAX_CLUSTERS entries, a divider run
//             per active cluster, no input taken during the reset
//             sweep
// o_s_tready is low while a beat is worked on; a result waits in the output
//             register, so the next beat may enter before it is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hue_kmeans_iteration_defines.svh"

module hue_kmeans_iteration
    import hkm_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int MAX_PIXELS   = MAX_PIXELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [15:0] hue
    input  logic                  i_s_tuser,   // [0] func
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [2:0] label, [37:3] adjustment,
                                               // [38] converged, [39] zero
    output logic                  o_m_tuser,   // [0] pass_done
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int K_W     = $clog2(MAX_CLUSTERS + 1);
    localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W   = CNT_W + HUE_W;
    localparam int INITN_W = IDX_W + FRAC_W;
    localparam int DIVN_W  = (SUM_W > INITN_W) ? SUM_W : INITN_W;
    localparam int DIVD_W  = (CNT_W > K_W) ? CNT_W : K_W;
    localparam int TOTR_W  = SQ_W + K_W;
    localparam int TOT_W   = (TOTR_W > ADJ_W) ? TOTR_W : ADJ_W + 1;

    // configuration
    logic [NUMK_W-1:0] r_num_k;
    logic [ADJ_W-1:0]  r_thr;
    logic [K_W-1:0]    k_act;

    // cluster store
    logic [HUE_W-1:0] r_cent_mem [MAX_CLUSTERS];
    logic [SUM_W-1:0] r_sum_mem  [MAX_CLUSTERS];
    logic [CNT_W-1:0] r_cnt_mem  [MAX_CLUSTERS];

    // sequencer state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [HUE_W-1:0]    r_hue, n_hue;
    logic                r_last, n_last;
    logic                r_item, n_item;
    logic [SQ_W-1:0]     r_best, n_best;
    logic [IDX_W-1:0]    r_label, n_label;
    logic [TOT_W-1:0]    r_total, n_total;
    logic                r_pass, n_pass;

    // output register
    logic                r_out_valid;
    logic [LABEL_W-1:0]  r_out_label;
    logic                r_out_pass;
    logic [ADJ_W-1:0]    r_out_adj;
    logic                r_out_conv;

    logic s_acc;
    logic out_free;
    logic out_load;

    logic [HUE_W-1:0] c_rd;
    logic [SUM_W-1:0] s_rd;
    logic [CNT_W-1:0] n_rd;

    logic idx_in;
    logic idx_lastk;
    logic idx_top;

    logic [HUE_W-1:0] op_b;
    logic [HUE_W-1:0] hue_diff;
    logic [SQ_W-1:0]  sq;
    logic             take;
    logic [IDX_W-1:0] lbl_nx;

    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DIVN_W-1:0] div_num;
    logic [DIVD_W-1:0] div_den;
    logic [DIVN_W-1:0] div_quot;

    logic             cent_we;
    logic [HUE_W-1:0] cent_val;
    logic             acc_we;
    logic             clr_we;

    logic [ADJ_W-1:0] adj_sat;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_k <= NUMK_RESET;
            r_thr   <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_CLUSTERS: r_num_k <= i_cfg_data[NUMK_W-1:0];
                CFG_THRESHOLD:    r_thr   <= i_cfg_data[ADJ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_num_k == '0) begin
            k_act = K_W'(1);
        end else if ({1'b0, r_num_k} > (NUMK_W + 1)'(MAX_CLUSTERS)) begin
            k_act = K_W'(MAX_CLUSTERS);
        end else begin
            k_act = K_W'(r_num_k);
        end
    end

    // single read port at r_idx
    assign c_rd = r_cent_mem[r_idx];
    assign s_rd = r_sum_mem[r_idx];
    assign n_rd = r_cnt_mem[r_idx];

    assign idx_in    = K_W'(r_idx) < k_act;
    assign idx_lastk = (K_W'(r_idx) + K_W'(1)) == k_act;
    assign idx_top   = r_idx == IDX_W'(MAX_CLUSTERS - 1);

    // shared distance unit
    assign op_b     = (r_state == S_UPD_WAIT) ? div_quot[HUE_W-1:0] : r_hue;
    assign hue_diff = (c_rd > op_b) ? c_rd - op_b : op_b - c_rd;
    assign sq       = SQ_W'(hue_diff) * SQ_W'(hue_diff);
    assign take     = (r_idx == '0) || (sq < r_best);
    assign lbl_nx   = take ? r_idx : r_label;

    // divider operands
    always_comb begin
        if (r_state == S_INIT) begin
            div_num = DIVN_W'({r_idx, {FRAC_W{1'b0}}});
            div_den = DIVD_W'(k_act);
        end else begin
            div_num = DIVN_W'(s_rd) + DIVN_W'(n_rd >> 1);
            div_den = DIVD_W'(n_rd);
        end
    end

    hkm_div #(
        .NUM_W (DIVN_W),
        .DEN_W (DIVD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign out_load = (r_state == S_DONE) && out_free;
    assign adj_sat  = (r_total > TOT_W'(ADJ_MAX)) ? ADJ_MAX : r_total[ADJ_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (i_s_tuser == FUNC_INIT) ? S_INIT : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (idx_lastk) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_last ? S_UPD : S_DONE;
            end
            S_UPD: begin
                if (idx_in && n_rd != '0) begin
                    n_state = S_UPD_WAIT;
                end else if (idx_top) begin
                    n_state = S_DONE;
                end
            end
            S_UPD_WAIT: begin
                if (div_done) begin
                    n_state = idx_top ? S_DONE : S_UPD;
                end
            end
            S_INIT: begin
                if (idx_in) begin
                    n_state = S_INIT_WAIT;
                end else if (idx_top) begin
                    n_state = r_item ? S_DONE : S_IDLE;
                end
            end
            S_INIT_WAIT: begin
                if (div_done) begin
                    if (idx_top) begin
                        n_state = r_item ? S_DONE : S_IDLE;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_idx     = r_idx;
        n_hue     = r_hue;
        n_last    = r_last;
        n_item    = r_item;
        n_best    = r_best;
        n_label   = r_label;
        n_total   = r_total;
        n_pass    = r_pass;
        div_start = 1'b0;
        cent_we   = 1'b0;
        cent_val  = '0;
        acc_we    = 1'b0;
        clr_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_hue   = i_s_tdata[HUE_W-1:0];
                    n_last  = i_s_tlast;
                    n_item  = 1'b1;
                    n_idx   = '0;
                    n_label = '0;
                    n_total = '0;
                    n_pass  = 1'b0;
                end
            end
            S_SEARCH: begin
                if (take) begin
                    n_best = sq;
                end
                n_label = lbl_nx;
                n_idx   = idx_lastk ? lbl_nx : r_idx + IDX_W'(1);
            end
            S_ACC: begin
                if (n_rd < CNT_W'(MAX_PIXELS)) begin
                    acc_we = 1'b1;
                end
                if (r_last) begin
                    n_idx  = '0;
                    n_pass = 1'b1;
                end
            end
            S_UPD: begin
                if (idx_in && n_rd != '0) begin
                    div_start = 1'b1;
                end else begin
                    clr_we = 1'b1;
                    if (!idx_top) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_UPD_WAIT: begin
                if (div_done) begin
                    cent_we  = 1'b1;
                    cent_val = div_quot[HUE_W-1:0];
                    clr_we   = 1'b1;
                    n_total  = r_total + TOT_W'(sq);
                    if (!idx_top) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_INIT: begin
                if (idx_in) begin
                    div_start = 1'b1;
                end else begin
                    cent_we = 1'b1;
                    clr_we  = 1'b1;
                    if (!idx_top) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_INIT_WAIT: begin
                if (div_done) begin
                    cent_we  = 1'b1;
                    cent_val = QUARTER + div_quot[HUE_W-1:0];
                    clr_we   = 1'b1;
                    if (!idx_top) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_item  <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_item  <= n_item;
            r_pass  <= n_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue   <= n_hue;
        r_last  <= n_last;
        r_best  <= n_best;
        r_label <= n_label;
        r_total <= n_total;
    end

    always_ff @(posedge i_clk) begin
        if (cent_we) begin
            r_cent_mem[r_idx] <= cent_val;
        end
        if (clr_we) begin
            r_sum_mem[r_idx] <= '0;
            r_cnt_mem[r_idx] <= '0;
        end else if (acc_we) begin
            r_sum_mem[r_idx] <= s_rd + SUM_W'(r_hue);
            r_cnt_mem[r_idx] <= n_rd + CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_label <= LABEL_W'(r_label);
            r_out_pass  <= r_pass;
            r_out_adj   <= r_pass ? adj_sat : '0;
            r_out_conv  <= r_pass && (adj_sat <= r_thr);
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_conv, r_out_adj, r_out_label};
    assign o_m_tuser  = r_out_pass;

    `HKM_ASSERT_SAME(a_div_free, div_start, !div_busy)
    `HKM_ASSERT_SAME(a_acc_active, r_state == S_ACC, K_W'(r_idx) < k_act)
    `HKM_ASSERT_SAME(a_init_quiet, r_out_valid && !r_out_pass, r_out_adj == '0 && !r_out_conv)
    `HKM_ASSERT_SAME(a_conv_match, r_out_valid && r_out_pass, r_out_conv == (r_out_adj <= r_thr))
    `HKM_ASSERT_NEXT(a_upd_end, r_state == S_UPD_WAIT && div_done && idx_top, r_state == S_DONE)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for hue_kmeans_iteration: directed and random pixel
// passes with init beats, both config registers, random stalls on both
// streams, every result checked field by field against a local k-means model
// ----------------------------------------------------------------------------
module tb;
    import hkm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int HUE_TOP        = (1 << HUE_W) - 1;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               pass_done;
        logic [ADJ_W-1:0]   adjustment;
        logic               converged;
    } t_hue_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;   // [15:0] hue
    logic                  i_s_tuser;   // [0] func
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;   // [2:0] label, [37:3] adjustment,
                                        // [38] converged, [39] zero
    logic                  o_m_tuser;   // [0] pass_done
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // model state
    logic [HUE_W-1:0]  mdl_centroid [MAX_CLUSTERS_DEF];
    logic [35:0]       mdl_hue_sum  [MAX_CLUSTERS_DEF];
    logic [20:0]       mdl_members  [MAX_CLUSTERS_DEF];
    logic [NUMK_W-1:0] mdl_num_k;
    logic [ADJ_W-1:0]  mdl_threshold;

    t_hue_result awaited_results [$];
    int unsigned mismatch_count = 0;
    int unsigned beats_sent     = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    bit          s_held         = 1'b0;

    hue_kmeans_iteration u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned active_clusters();
        if (mdl_num_k == 0) return 1;
        if (mdl_num_k > MAX_CLUSTERS_DEF) return MAX_CLUSTERS_DEF;
        return mdl_num_k;
    endfunction

    function automatic void place_centroids();
        int unsigned k;
        k = active_clusters();
        for (int i = 0; i < MAX_CLUSTERS_DEF; i++) begin
            if (i < k) begin
                mdl_centroid[i] = QUARTER + HUE_W'((i << FRAC_W) / k);
            end else begin
                mdl_centroid[i] = '0;
            end
            mdl_hue_sum[i] = '0;
            mdl_members[i] = '0;
        end
    endfunction

    function automatic longint unsigned hue_dist_sq(input logic [HUE_W-1:0] a,
                                                    input logic [HUE_W-1:0] b);
        longint unsigned diff;
        diff = (a > b) ? a - b : b - a;
        return diff * diff;
    endfunction

    function automatic t_hue_result next_cluster_result(input logic func,
                                                        input logic [HUE_W-1:0] hue,
                                                        input logic last);
        t_hue_result     res;
        int unsigned     k;
        longint unsigned best, cand, total, members, mean;
        res = '0;
        if (func == FUNC_INIT) begin
            place_centroids();
            return res;
        end
        k = active_clusters();
        best = hue_dist_sq(mdl_centroid[0], hue);
        for (int j = 1; j < k; j++) begin
            cand = hue_dist_sq(mdl_centroid[j], hue);
            if (cand < best) begin
                best = cand;
                res.label = LABEL_W'(j);
            end
        end
        if (mdl_members[res.label] < MAX_PIXELS_DEF) begin
            mdl_members[res.label] = mdl_members[res.label] + 1'b1;
            mdl_hue_sum[res.label] = mdl_hue_sum[res.label] + hue;
        end
        if (last) begin
            total = 0;
            for (int j = 0; j < k; j++) begin
                members = mdl_members[j];
                if (members != 0) begin
                    mean = (mdl_hue_sum[j] + members / 2) / members;
                    total += hue_dist_sq(mdl_centroid[j], HUE_W'(mean));
                    mdl_centroid[j] = HUE_W'(mean);
                end
            end
            for (int j = 0; j < MAX_CLUSTERS_DEF; j++) begin
                mdl_hue_sum[j] = '0;
                mdl_members[j] = '0;
            end
            if (total > ADJ_MAX) total = ADJ_MAX;
            res.pass_done  = 1'b1;
            res.adjustment = ADJ_W'(total);
            res.converged  = (total <= mdl_threshold);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_beat(input logic func, input logic [HUE_W-1:0] hue,
                             input logic last, output t_hue_result res);
        if ($urandom_range(99) < tx_idle_pct) begin
            if (s_held) i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= hue;
        i_s_tuser  <= func;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        s_held = 1'b1;
        res = next_cluster_result(func, hue, last);
        awaited_results.push_back(res);
        beats_sent++;
    endtask

    task automatic wait_drained();
        if (s_held) begin
            i_s_tvalid <= 1'b0;
            s_held = 1'b0;
        end
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    task automatic set_config(input logic [NUMK_W-1:0] k, input logic [ADJ_W-1:0] thr);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_NUM_CLUSTERS;
        i_cfg_data  <= CFG_DATA_W'(k);
        do @(posedge i_clk); while (!o_cfg_ready);
        mdl_num_k = k;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= CFG_DATA_W'(thr);
        do @(posedge i_clk); while (!o_cfg_ready);
        mdl_threshold = thr;
        i_cfg_valid <= 1'b0;
    endtask

    // centroids from reset: 0x1000 and 0x3000
    task automatic test_reset_state();
        t_hue_result res;
        send_beat(FUNC_PIXEL, '0, 1'b0, res);
        // midway between the two centroids, tie goes to cluster 0
        send_beat(FUNC_PIXEL, 16'h2000, 1'b0, res);
        send_beat(FUNC_PIXEL, 16'h3000, 1'b0, res);
        send_beat(FUNC_PIXEL, '1, 1'b1, res);
        // cluster 1 left empty, keeps its centroid
        send_beat(FUNC_PIXEL, '0, 1'b1, res);
    endtask

    // zero acts as one cluster, values past the maximum act as the maximum
    task automatic test_cluster_count();
        logic [NUMK_W-1:0] counts [3];
        t_hue_result       res;
        counts = '{NUMK_W'(0), NUMK_W'(15), NUMK_W'(1)};
        foreach (counts[n]) begin
            set_config(counts[n], THR_RESET);
            send_beat(FUNC_INIT, '1, counts[n] == 15, res);
            send_beat(FUNC_PIXEL, '0, 1'b0, res);
            send_beat(FUNC_PIXEL, '1, 1'b1, res);
        end
    endtask

    task automatic test_threshold();
        t_hue_result res;
        set_config(NUMK_W'(1), '0);
        send_beat(FUNC_INIT, '0, 1'b0, res);
        send_beat(FUNC_PIXEL, '1, 1'b1, res);
        // no movement, equal to a zero threshold
        send_beat(FUNC_PIXEL, '1, 1'b1, res);
        set_config(NUMK_W'(8), ADJ_MAX);
        send_beat(FUNC_INIT, '0, 1'b0, res);
        send_beat(FUNC_PIXEL, '0, 1'b1, res);
        // init in the middle of a pass drops what was summed so far
        send_beat(FUNC_PIXEL, 16'd100, 1'b0, res);
        send_beat(FUNC_INIT, 16'd7, 1'b1, res);
        send_beat(FUNC_PIXEL, 16'd200, 1'b1, res);
    endtask

    task automatic test_random_runs(input int unsigned sender_idle,
                                    input int unsigned receiver_idle,
                                    input int unsigned beats);
        logic [HUE_W-1:0]  points  [32];
        logic [HUE_W-1:0]  centers [MAX_CLUSTERS_DEF];
        logic [NUMK_W-1:0] k;
        logic [ADJ_W-1:0]  thr;
        t_hue_result       res;
        int unsigned       start, n_points, n_centers, spread, passes, roll;
        int                h;
        tx_idle_pct = sender_idle;
        rx_idle_pct = receiver_idle;
        start = beats_sent;
        while (beats_sent - start < beats) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                k = ($urandom_range(4) == 0) ? NUMK_W'($urandom_range(15))
                                             : NUMK_W'($urandom_range(1, MAX_CLUSTERS_DEF));
                case ($urandom_range(4))
                    0: thr = '0;
                    1: thr = ADJ_MAX;
                    2: thr = THR_RESET;
                    3: thr = ADJ_W'($urandom_range(0, 1 << 30));
                    default: thr = ADJ_W'({$urandom, $urandom});
                endcase
                set_config(k, thr);
            end else if (roll < 16) begin
                wait_drained();
            end
            if (roll < 85) begin
                // data set drawn around a few random hue centers, run for up to six passes or until converged
                n_points  = $urandom_range(1, 32);
                n_centers = $urandom_range(1, MAX_CLUSTERS_DEF);
                spread    = 1 << $urandom_range(3, 13);
                for (int c = 0; c < n_centers; c++) centers[c] = HUE_W'($urandom);
                for (int i = 0; i < n_points; i++) begin
                    if ($urandom_range(19) == 0) begin
                        points[i] = $urandom_range(1) ? '1 : '0;
                    end else begin
                        h = int'(centers[$urandom_range(n_centers - 1)])
                            + int'($urandom_range(2 * spread)) - int'(spread);
                        points[i] = (h < 0) ? '0 : (h > HUE_TOP) ? '1 : HUE_W'(h);
                    end
                end
                if ($urandom_range(3) != 0) begin
                    send_beat(FUNC_INIT, HUE_W'($urandom), 1'($urandom_range(1)), res);
                end
                res = '0;
                passes = $urandom_range(1, 6);
                for (int p = 0; p < passes && !res.converged; p++) begin
                    for (int i = 0; i < n_points; i++) begin
                        send_beat(FUNC_PIXEL, points[i], i == n_points - 1, res);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_beat(1'($urandom_range(1)), HUE_W'($urandom),
                              $urandom_range(3) == 0, res);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_hue_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result beat with nothing awaited, tdata", o_m_tdata, 0);
            end else begin
                want = awaited_results.pop_front();
                if (o_m_tdata[LABEL_W-1:0] !== want.label)
                    report_mismatch("label", o_m_tdata[LABEL_W-1:0], want.label);
                if (o_m_tuser !== want.pass_done)
                    report_mismatch("pass_done", o_m_tuser, want.pass_done);
                if (o_m_tdata[LABEL_W +: ADJ_W] !== want.adjustment)
                    report_mismatch("adjustment", o_m_tdata[LABEL_W +: ADJ_W],
                                    want.adjustment);
                if (o_m_tdata[LABEL_W + ADJ_W] !== want.converged)
                    report_mismatch("converged", o_m_tdata[LABEL_W + ADJ_W], want.converged);
            end
        end
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("hue_kmeans_iteration test failed");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_s_tlast   <= 1'b0;
        i_m_tready  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mdl_num_k     = NUMK_RESET;
        mdl_threshold = THR_RESET;
        place_centroids();
        tx_idle_pct = 7;
        rx_idle_pct = 56;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_cluster_count();
        test_threshold();
        test_random_runs(7, 56, 640);
        test_random_runs(56, 7, 640);
        test_random_runs(0, 0, 650);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("hue_kmeans_iteration test passed");
        end else begin
            $display("hue_kmeans_iteration test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/hkm_pkg.sv
src/hkm_div.sv
src/hue_kmeans_iteration.sv
sim/tb.sv
